// ----- hdl/rk4_pkg.sv -----
// Package: shared types, constants and helpers for the RK4 integrator.
`timescale 1ns / 1ps
package rk4_pkg;

  localparam int FracBits = 16;
  localparam int NumRegs  = 8;
  localparam int GainW    = 31;
  localparam int StepW    = 16;
  localparam int DataW    = 32;
  localparam int RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegSpringX  = 3'd0;
  localparam logic [RegIdxW-1:0] RegSpringY  = 3'd1;
  localparam logic [RegIdxW-1:0] RegSpringZ  = 3'd2;
  localparam logic [RegIdxW-1:0] RegDampX    = 3'd3;
  localparam logic [RegIdxW-1:0] RegDampY    = 3'd4;
  localparam logic [RegIdxW-1:0] RegDampZ    = 3'd5;
  localparam logic [RegIdxW-1:0] RegInvMass  = 3'd6;
  localparam logic [RegIdxW-1:0] RegStepTime = 3'd7;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,     // latch axis state and force, clear accumulators
    OpKx,       // p = K * xs
    OpQv,       // p = Q * vs, acc = F - rnd(p_prev)
    OpSum,      // s = sat(acc - rnd(p))
    OpMass,     // p = invm * s
    OpKv,       // kv = sat(rnd(p)); accumulate weighted k
    OpHx,       // p = h * kx
    OpHv,       // p = h * kv, xs = sat(x + rnd(p_prev))
    OpStage,    // vs = sat(v + rnd(p))
    OpFinX,     // p = h * sumx (wide)
    OpFinV,     // xn = sat(x + p/6 ...), p = h * sumv
    OpFinW      // vn, write back
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
    logic [1:0] stage;   // RK stage 0..3
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction

  // floor((p + 2^(sh-1)) / 2^sh)
  function automatic logic signed [71:0] rnd_shift(input logic signed [71:0] p,
                                                   input int unsigned sh);
    logic signed [71:0] n;
    n = p + (72'sd1 <<< (sh - 1));
    return n >>> sh;
  endfunction

endpackage

// ----- hdl/rk4_datapath.sv -----
// Datapath: shared multiplier, accumulators and per-axis state registers.
`timescale 1ns / 1ps
module rk4_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rk4_pkg::cmd_t                     cmd_i,
  input  logic signed [rk4_pkg::DataW-1:0]  force_i [3],
  input  logic [rk4_pkg::GainW-1:0]         spring_i [3],
  input  logic [rk4_pkg::GainW-1:0]         damp_i [3],
  input  logic [rk4_pkg::GainW-1:0]         invm_i,
  input  logic [rk4_pkg::StepW-1:0]         step_i,
  output logic signed [rk4_pkg::DataW-1:0]  pos_o [3],
  output logic signed [rk4_pkg::DataW-1:0]  vel_o [3]
);
  import rk4_pkg::*;

  // 3 * 2^32: beyond this the final sum saturates anyway.
  localparam logic signed [71:0] Div6Lim = 72'sd12884901888;

  logic signed [DataW-1:0] pos_q [3];
  logic signed [DataW-1:0] vel_q [3];
  logic signed [DataW-1:0] x_q, v_q, f_q, xs_q, vs_q, kx_q, kv_q, s_q;
  logic signed [35:0] sumx_q, sumv_q;
  logic signed [71:0] p_q, acc_q;
  logic signed [35:0] mb;
  logic signed [32:0] ma;
  logic signed [71:0] prod;
  logic signed [71:0] hsh;
  logic signed [71:0] qx_q;
  logic signed [DataW-1:0] x_new, v_new;
  logic [1:0] ax;

  assign ax = cmd_i.axis;

  // One shared multiplier; operands chosen by the current operation.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OpKx:   begin ma = {2'b00, spring_i[ax]}; mb = 36'(xs_q); end
      OpQv:   begin ma = {2'b00, damp_i[ax]};   mb = 36'(vs_q); end
      OpMass: begin ma = {2'b00, invm_i};       mb = 36'(s_q); end
      OpHx:   begin ma = 33'($signed({1'b0, step_i})); mb = 36'(kx_q); end
      OpHv:   begin ma = 33'($signed({1'b0, step_i})); mb = 36'(kv_q); end
      OpFinX: begin ma = 33'($signed({1'b0, step_i})); mb = sumx_q; end
      OpFinV: begin ma = 33'($signed({1'b0, step_i})); mb = sumv_q; end
      default: ;
    endcase
    prod = 72'(ma) * 72'(mb);
  end

  // Half step for stages 0 and 1, full step for stage 2.
  always_comb begin
    hsh = (cmd_i.stage == 2'd2) ? rnd_shift(p_q, FracBits)
                                : rnd_shift(p_q, FracBits + 1);
  end

  // floor((p + 3*2^S) / (6*2^S)): shift by S+1, clamp to where the final sum
  // still matters, then floor divide by 3. With 2^16 = 1 mod 3,
  // u/3 = uh*21845 + (uh+ul)/3; the small quotient uses a reciprocal multiply.
  function automatic logic signed [71:0] div6r(input logic signed [71:0] p);
    logic signed [71:0] n, t;
    logic [34:0] u;
    logic [19:0] w;
    logic [39:0] wq;
    logic [34:0] q;
    n = p + (72'sd3 <<< FracBits);
    t = n >>> (FracBits + 1);       // floor(n / 2^(S+1))
    if (t > Div6Lim) u = 35'd25769803776;
    else if (t < -Div6Lim) u = '0;
    else u = 35'(t + Div6Lim);
    w  = 20'(u[34:16]) + 20'(u[15:0]);
    wq = 40'(w) * 40'd699051;       // (2^21 + 1) / 3
    q  = 35'(u[34:16]) * 35'd21845 + 35'(wq[39:21]);
    return 72'($signed({1'b0, q})) - 72'sd4294967296;
  endfunction

  always_comb begin
    x_new = sat32(72'(x_q) + qx_q);
    v_new = sat32(72'(v_q) + div6r(p_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else if (cmd_i.op == OpFinW) begin
      pos_q[ax] <= x_new;
      vel_q[ax] <= v_new;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLoad: begin
        x_q <= pos_q[ax]; v_q <= vel_q[ax]; f_q <= force_i[ax];
        xs_q <= pos_q[ax]; vs_q <= vel_q[ax];
        sumx_q <= '0; sumv_q <= '0;
      end
      OpKx: begin p_q <= prod; kx_q <= vs_q; end
      OpQv: begin p_q <= prod; acc_q <= 72'(f_q) - rnd_shift(p_q, FracBits); end
      OpSum: s_q <= sat32(acc_q - rnd_shift(p_q, FracBits));
      OpMass: p_q <= prod;
      OpKv: begin
        kv_q <= sat32(rnd_shift(p_q, FracBits));
        if (cmd_i.stage == 2'd1 || cmd_i.stage == 2'd2) begin
          sumx_q <= sumx_q + (36'(kx_q) <<< 1);
          sumv_q <= sumv_q + (36'(sat32(rnd_shift(p_q, FracBits))) <<< 1);
        end else begin
          sumx_q <= sumx_q + 36'(kx_q);
          sumv_q <= sumv_q + 36'(sat32(rnd_shift(p_q, FracBits)));
        end
      end
      OpHx: p_q <= prod;
      OpHv: begin p_q <= prod; xs_q <= sat32(72'(x_q) + hsh); end
      OpStage: begin
        if (cmd_i.stage == 2'd2)
          vs_q <= sat32(72'(v_q) + rnd_shift(p_q, FracBits));
        else
          vs_q <= sat32(72'(v_q) + rnd_shift(p_q, FracBits + 1));
      end
      OpFinX: p_q <= prod;
      OpFinV: begin p_q <= prod; qx_q <= div6r(p_q); end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_o[i] = pos_q[i];
      vel_o[i] = vel_q[i];
    end
  end

endmodule

// ----- hdl/rk4_ctrl.sv -----
// Controller: sequences the RK4 operations over three axes.
`timescale 1ns / 1ps
module rk4_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output rk4_pkg::cmd_t cmd_o,
  output rk4_pkg::sts_t sts_o
);
  import rk4_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StLoad  = 4'd1;
  localparam logic [3:0] StKx    = 4'd2;
  localparam logic [3:0] StQv    = 4'd3;
  localparam logic [3:0] StSum   = 4'd4;
  localparam logic [3:0] StMass  = 4'd5;
  localparam logic [3:0] StKv    = 4'd6;
  localparam logic [3:0] StHx    = 4'd7;
  localparam logic [3:0] StHv    = 4'd8;
  localparam logic [3:0] StStage = 4'd9;
  localparam logic [3:0] StFinX  = 4'd10;
  localparam logic [3:0] StFinV  = 4'd11;
  localparam logic [3:0] StFinW  = 4'd12;
  localparam logic [3:0] StWb    = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d, stage_q, stage_d;
  logic done_d;

  always_comb begin
    state_d = state_q; axis_d = axis_q; stage_d = stage_q; done_d = 1'b0;
    cmd_o.op = OpNone; cmd_o.axis = axis_q; cmd_o.stage = stage_q;
    unique case (state_q)
      StIdle:  if (start_i) begin state_d = StLoad; axis_d = '0; end
      StLoad:  begin cmd_o.op = OpLoad; stage_d = '0; state_d = StKx; end
      StKx:    begin cmd_o.op = OpKx; state_d = StQv; end
      StQv:    begin cmd_o.op = OpQv; state_d = StSum; end
      StSum:   begin cmd_o.op = OpSum; state_d = StMass; end
      StMass:  begin cmd_o.op = OpMass; state_d = StKv; end
      StKv:    begin
        cmd_o.op = OpKv;
        state_d = (stage_q == 2'd3) ? StFinX : StHx;
      end
      StHx:    begin cmd_o.op = OpHx; state_d = StHv; end
      StHv:    begin cmd_o.op = OpHv; state_d = StStage; end
      StStage: begin cmd_o.op = OpStage; stage_d = stage_q + 2'd1; state_d = StKx; end
      StFinX:  begin cmd_o.op = OpFinX; state_d = StFinV; end
      StFinV:  begin cmd_o.op = OpFinV; state_d = StFinW; end
      StFinW:  begin cmd_o.op = OpFinW; state_d = StWb; end
      StWb:    begin
        if (axis_q == 2'd2) begin
          state_d = StIdle; done_d = 1'b1;
        end else begin
          axis_d = axis_q + 2'd1; state_d = StLoad;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; axis_q <= '0; stage_q <= '0; sts_o <= '0;
    end else begin
      state_q <= state_d; axis_q <= axis_d; stage_q <= stage_d;
      sts_o.done <= done_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3) else $error("axis counter out of range");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |-> state_q == StIdle) else $error("done while busy");
  a_start_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && start_i) |=> state_q == StLoad) else $error("start lost");

endmodule

// ----- hdl/impedance_rk4_integrator.sv -----
// Top level: three-axis mass-spring-damper RK4 integrator.
// Usage:
//  - s_axis carries one force transaction (x, y, z); m_axis returns the new
//    offsets and velocities, one result transaction per input.
//  - Config: cfg_we_i/cfg_idx_i/cfg_data_i write gain registers; write only
//    while idle.
//  - The three axes are worked in turn on the single shared 33x36
//    multiplier, which every RK stage uses in turn.
//  - One item is worked at a time; s_axis_tready is low while computing or
//    while a result is waiting in the output register.
//  - Reset clears state to zero and gains to their defaults
//    (inverse mass 1.0, step 66).
//  - If the receiver stalls, the result is held in the output register.
`timescale 1ns / 1ps
module impedance_rk4_integrator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // force_x, force_y, force_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // offset_x,y,z, velocity_x,y,z
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);
  import rk4_pkg::*;

  logic [GainW-1:0] spring_q [3];
  logic [GainW-1:0] damp_q [3];
  logic [GainW-1:0] invm_q;
  logic [StepW-1:0] step_q;
  logic signed [DataW-1:0] force_q [3];
  logic signed [DataW-1:0] pos [3];
  logic signed [DataW-1:0] vel [3];
  logic busy, start, out_valid_q;
  logic start_q;
  logic [191:0] out_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin spring_q[i] <= '0; damp_q[i] <= '0; end
      invm_q <= 31'd65536;
      step_q <= 16'd66;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSpringX:  spring_q[0] <= cfg_data_i;
        RegSpringY:  spring_q[1] <= cfg_data_i;
        RegSpringZ:  spring_q[2] <= cfg_data_i;
        RegDampX:    damp_q[0] <= cfg_data_i;
        RegDampY:    damp_q[1] <= cfg_data_i;
        RegDampZ:    damp_q[2] <= cfg_data_i;
        RegInvMass:  invm_q <= cfg_data_i;
        RegStepTime: step_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy && !out_valid_q && !start_q && !sts.done;
  assign start = 1'b0 | (s_axis_tvalid && s_axis_tready);

  always_ff @(posedge clk_i) begin
    if (start) begin
      force_q[0] <= s_axis_tdata[31:0];
      force_q[1] <= s_axis_tdata[63:32];
      force_q[2] <= s_axis_tdata[95:64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b0;
    else start_q <= start;
  end

  rk4_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start_q), .busy_o(busy), .cmd_o(cmd), .sts_o(sts)
  );

  rk4_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .force_i(force_q), .spring_i(spring_q),
    .damp_i(damp_q), .invm_i(invm_q), .step_i(step_q), .pos_o(pos), .vel_o(vel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (sts.done) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (sts.done) out_q <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- test/tb_impedance_rk4_integrator.sv -----
// Testbench: impedance_rk4_integrator checked against a cycle-free RK4 predictor.
`timescale 1ns / 1ps
module tb_impedance_rk4_integrator;
  import rk4_pkg::*;

  // One directed row: either a register write or a force transaction.
  // Rows with has_result carry a result that can be read off at a glance.
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [30:0] data;
    logic [95:0] force_word;
    bit          has_result;
    logic [191:0] result;
  } stim_row_t;

  localparam int S = FracBits;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 240;
  localparam int LongHoldCycles = 400;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;    // force_x, force_y, force_z (lowest bits first)
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;    // offset_x/y/z, velocity_x/y/z (lowest first)
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [30:0]  cfg_data_i;

  // Predictor copy of the block: gains and per-axis state.
  longint       gain_reg [NumRegs];
  int           pos_state [3];
  int           vel_state [3];
  logic [191:0] pending_states [$];
  stim_row_t    stim_table [$];
  int           errors;
  int           results_seen;
  bit           done_sending;

  impedance_rk4_integrator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers for the predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Round to nearest by a power of two, ties upward.
  function automatic longint round_shift(longint p, int sh);
    return (p + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Round to nearest for a general positive divisor (floor of p + d/2).
  function automatic longint round_div(longint p, longint d);
    longint n;
    longint q;
    n = p + d / 2;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic int axis_accel(int x, int v, int f, int a);
    int s;
    s = clamp32(longint'(f) - round_shift(gain_reg[a] * longint'(x), S)
                - round_shift(gain_reg[3 + a] * longint'(v), S));
    return clamp32(round_shift(gain_reg[RegInvMass] * longint'(s), S));
  endfunction

  // Advance the three axes by one RK4 step; returns the packed result word.
  function automatic logic [191:0] advance_axes(logic [95:0] force_word);
    longint h;
    int     f, x, v, sx, sv;
    int     kx [4];
    int     kv [4];
    longint sumx, sumv;
    logic [191:0] r;
    h = gain_reg[RegStepTime];
    for (int a = 0; a < 3; a++) begin
      f = force_word[32*a +: 32];
      x = pos_state[a];
      v = vel_state[a];
      kx[0] = v;
      kv[0] = axis_accel(x, v, f, a);
      for (int st = 1; st < 4; st++) begin
        // stages two and three step by half, the fourth by the full step
        sx = clamp32(longint'(x) + round_shift(h * kx[st-1], (st < 3) ? S + 1 : S));
        sv = clamp32(longint'(v) + round_shift(h * kv[st-1], (st < 3) ? S + 1 : S));
        kx[st] = sv;
        kv[st] = axis_accel(sx, sv, f, a);
      end
      sumx = longint'(kx[0]) + 2 * longint'(kx[1]) + 2 * longint'(kx[2]) + kx[3];
      sumv = longint'(kv[0]) + 2 * longint'(kv[1]) + 2 * longint'(kv[2]) + kv[3];
      pos_state[a] = clamp32(longint'(x) + round_div(h * sumx, 64'sd6 <<< S));
      vel_state[a] = clamp32(longint'(v) + round_div(h * sumv, 64'sd6 <<< S));
    end
    for (int a = 0; a < 3; a++) begin
      r[32*a +: 32]     = pos_state[a];
      r[32*(a+3) +: 32] = vel_state[a];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender-side tasks
  // ---------------------------------------------------------------------------
  // Leaves cfg_we_i high; the caller lowers it after the last write of a batch.
  task automatic write_gain(logic [2:0] idx, logic [30:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    gain_reg[idx] = (idx == RegStepTime) ? longint'(data[15:0]) : longint'(data);
  endtask

  // Valid stays high on return so back-to-back transactions need no re-raise.
  task automatic send_force(logic [95:0] force_word, bit has_result,
                            logic [191:0] result);
    logic [191:0] predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= force_word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = advance_axes(force_word);
    pending_states.push_back(has_result ? result : predicted);
  endtask

  // Block is idle once the last result is out; one item always gives one result.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    @(posedge clk_i);
    while (pending_states.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [95:0] random_force();
    logic [95:0] w;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 7) == 0) w[32*a +: 32] = $urandom();
      else w[32*a +: 32] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    return w;
  endfunction

  function automatic logic [30:0] random_gain(logic [2:0] idx);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (idx == RegStepTime) ? 31'd65535 : 31'h7fffffff;
      2: return 31'($urandom());
      default: begin
        if (idx == RegStepTime) return 31'($urandom_range(1, 2000));
        if (idx == RegInvMass) return 31'($urandom_range(1, 1 << 18));
        return 31'($urandom_range(0, 1 << 20));
      end
    endcase
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [30:0] data);
    stim_row_t r;
    r = '{1'b1, idx, data, '0, 1'b0, '0};
    stim_table.push_back(r);
  endfunction

  function automatic void add_force(int fx, int fy, int fz, bit has_result = 0,
                                    logic [191:0] result = '0);
    stim_row_t r;
    r = '{1'b0, '0, '0, {fz, fy, fx}, has_result, result};
    stim_table.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int burst_left;
    bit gappy;
    stim_row_t row;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    done_sending  = 1'b0;
    rst_ni        = 1'b0;
    for (int i = 0; i < NumRegs; i++) gain_reg[i] = 0;
    gain_reg[RegInvMass]  = 65536;
    gain_reg[RegStepTime] = 66;
    for (int a = 0; a < 3; a++) begin
      pos_state[a] = 0;
      vel_state[a] = 0;
    end

    // Directed: reset defaults, zero step, extremes, zero inverse mass, minimum step.
    add_force(0, 0, 0, 1, '0);                          // rest stays at rest
    add_cfg(RegStepTime, 31'd0);
    add_force(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, '0); // zero step: frozen
    add_cfg(RegStepTime, 31'd66);
    add_force(32'h7fffffff, 32'h80000000, 1);
    add_force(32'h80000000, 32'h7fffffff, -1);
    add_force(32'h0000ffff, 32'hffff0000, 32'h55555555);
    add_cfg(RegStepTime, 31'd65535);                    // largest step: saturation
    add_cfg(RegInvMass, 31'h7fffffff);
    add_force(32'h7fffffff, 32'h80000000, 32'haaaaaaaa);
    add_force(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    add_cfg(RegSpringX, 31'h7fffffff);
    add_cfg(RegSpringY, 31'h7fffffff);
    add_cfg(RegSpringZ, 31'h7fffffff);
    add_cfg(RegDampX, 31'h7fffffff);
    add_cfg(RegDampY, 31'h7fffffff);
    add_cfg(RegDampZ, 31'h7fffffff);
    add_force(32'h7fffffff, 32'h80000000, 0);
    add_force(0, 0, 0);
    add_cfg(RegInvMass, 31'd0);                         // zero inverse mass: coast
    add_force(32'h7fffffff, 32'h80000000, 32'h12345678);
    add_force(0, 0, 0);
    add_cfg(RegInvMass, 31'd1);
    add_cfg(RegStepTime, 31'd1);
    add_cfg(RegSpringX, 31'd65536);
    add_cfg(RegDampY, 31'd65536);
    add_force(32'h00010000, -32'sh00010000, 0);
    add_force(32'h80000000, 32'h7fffffff, 32'h80000000);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) begin
        if (i == 0 || !stim_table[i-1].is_cfg) drain_block();
        write_gain(row.idx, row.data);
        if (i + 1 < stim_table.size() && !stim_table[i+1].is_cfg) cfg_we_i <= 1'b0;
      end else begin
        send_force(row.force_word, row.has_result, row.result);
      end
    end

    // Random phases: new gains each phase, written only while idle.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_block();
      for (int r = 0; r < NumRegs; r++) write_gain(r[2:0], random_gain(r[2:0]));
      cfg_we_i <= 1'b0;
      gappy = ph[0];
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PhaseItems; n++) begin
        send_force(random_force(), 1'b0, '0);
        if (gappy && --burst_left == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    drain_block();
    done_sending = 1'b1;
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("** impedance_rk4_integrator: PASSED **");
    end else begin
      $display("** impedance_rk4_integrator: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    bit held;
    m_axis_tready = 1'b0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 300)) begin
        if (!held && results_seen >= 500) begin
          // long hold-off while the sender keeps offering transactions
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (LongHoldCycles) @(posedge clk_i);
        end
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  initial begin
    logic [191:0] want;
    string field_name [6] = '{"offset_x", "offset_y", "offset_z",
                             "velocity_x", "velocity_y", "velocity_z"};
    errors = 0;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_states.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = pending_states.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (m_axis_tdata[32*k +: 32] !== want[32*k +: 32]) begin
              $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                       $signed(want[32*k +: 32]), $signed(m_axis_tdata[32*k +: 32]));
              errors++;
            end
          end
        end
      end
    end
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #10000000;
    $display("** impedance_rk4_integrator: FAILED **");
    $finish;
  end

endmodule

// ----- impedance_rk4_integrator.f -----
hdl/rk4_pkg.sv
hdl/rk4_datapath.sv
hdl/rk4_ctrl.sv
hdl/impedance_rk4_integrator.sv
test/tb_impedance_rk4_integrator.sv
